// ===== hdl/bgs_pkg.sv =====
// ----------------------------------------------------------------------------
// bgs_pkg
// Shared constants and types of the barycentric gradient shader.
// ----------------------------------------------------------------------------
package bgs_pkg;

  // default coordinate width of one vertex axis
  localparam int COORD_BITS_DEF = 10;
  // channel and color widths
  localparam int CHAN_BITS  = 8;
  localparam int NUM_CHAN   = 3;
  localparam int COLOR_BITS = CHAN_BITS * NUM_CHAN;
  // quotient bits of the divider, one per stage
  localparam int QUO_BITS   = 8;
  // depth of the queue between front and back
  localparam int FIFO_DEPTH = 4;
  // configuration index width
  localparam int CFG_IDX_BITS = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_A = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_B = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_C = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLOR_A  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLOR_B  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLOR_C  = 3'd5;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== hdl/bgs_fifo.sv =====
// ----------------------------------------------------------------------------
// bgs_fifo
// Short register queue that decouples the front and back pipelines.
// ----------------------------------------------------------------------------
module bgs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bgs_pkg::FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    data_i,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    data_o,
  output bgs_pkg::fifo_stat_t stat_o
);
  import bgs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LAST) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LAST) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == FULLC);
  assign stat_o.empty = (cnt_q == '0);

endmodule

// ===== hdl/bgs_front.sv =====
// ----------------------------------------------------------------------------
// bgs_front
// Configuration registers, edge functions, area and coverage of each pixel.
// ----------------------------------------------------------------------------
module bgs_front #(
  parameter int COORD_BITS = bgs_pkg::COORD_BITS_DEF,
  localparam int VW = 2 * COORD_BITS,
  localparam int CFW = (VW > bgs_pkg::COLOR_BITS) ? VW : bgs_pkg::COLOR_BITS,
  localparam int PW = 2 * COORD_BITS + 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bgs_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFW-1:0]                    cfg_data_i,
  input  logic                              in_valid_i,
  input  logic [COORD_BITS-1:0]             in_x_i,
  input  logic [COORD_BITS-1:0]             in_y_i,
  output logic                              in_ready_o,
  input  bgs_pkg::fifo_stat_t               stat_i,
  output logic                              push_o,
  output logic [COORD_BITS-1:0]             x_o,
  output logic [COORD_BITS-1:0]             y_o,
  output logic                              cov_o,
  output logic [PW-1:0]                     ea_o,
  output logic [PW-1:0]                     eb_o,
  output logic [PW-1:0]                     ec_o,
  output logic [PW-1:0]                     area_o,
  output logic [bgs_pkg::COLOR_BITS-1:0]    color_a_o,
  output logic [bgs_pkg::COLOR_BITS-1:0]    color_b_o,
  output logic [bgs_pkg::COLOR_BITS-1:0]    color_c_o
);
  import bgs_pkg::*;

  localparam int N  = COORD_BITS;
  localparam int EW = PW + 1;

  logic [VW-1:0]         va_q, vb_q, vc_q;
  logic [COLOR_BITS-1:0] ca_q, cb_q, cc_q;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
      vb_q <= '0;
      vc_q <= '0;
      ca_q <= '0;
      cb_q <= '0;
      cc_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VERTEX_A: va_q <= cfg_data_i[VW-1:0];
        REG_VERTEX_B: vb_q <= cfg_data_i[VW-1:0];
        REG_VERTEX_C: vc_q <= cfg_data_i[VW-1:0];
        REG_COLOR_A:  ca_q <= cfg_data_i[COLOR_BITS-1:0];
        REG_COLOR_B:  cb_q <= cfg_data_i[COLOR_BITS-1:0];
        REG_COLOR_C:  cc_q <= cfg_data_i[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [N:0] sd(logic [N-1:0] a, logic [N-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic logic signed [EW-1:0] sub2(logic signed [PW-1:0] a,
                                                logic signed [PW-1:0] b);
    return $signed({a[PW-1], a}) - $signed({b[PW-1], b});
  endfunction

  logic [N-1:0] ax, ay, bx, by, cx, cy;
  assign ax = va_q[N-1:0];
  assign ay = va_q[VW-1:N];
  assign bx = vb_q[N-1:0];
  assign by = vb_q[VW-1:N];
  assign cx = vc_q[N-1:0];
  assign cy = vc_q[VW-1:N];

  // doubled signed area, products then difference
  logic signed [PW-1:0] ar1_q, ar2_q;
  logic signed [EW-1:0] area_c;
  logic [PW-1:0]        area_q;
  logic                 area_pos;
  assign area_c   = sub2(ar1_q, ar2_q);
  assign area_pos = !area_c[EW-1] && (area_c != '0);
  always_ff @(posedge clk_i) begin
    ar1_q  <= sd(ax, bx) * sd(ay, cy);
    ar2_q  <= sd(ax, cx) * sd(ay, by);
    area_q <= area_c[PW-1:0];
  end

  // stall when the last stage holds an item the queue cannot take
  logic v1_q, v2_q, en;
  assign en         = !(v2_q && stat_i.full);
  assign in_ready_o = en;
  assign push_o     = v2_q && !stat_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  // stage one: edge products
  logic signed [PW-1:0] pa1_q, pa2_q, pb1_q, pb2_q, pc1_q, pc2_q;
  logic [N-1:0]         x1_q, y1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pa1_q <= sd(bx, ax) * sd(in_y_i, ay);
      pa2_q <= sd(by, ay) * sd(in_x_i, ax);
      pb1_q <= sd(cx, bx) * sd(in_y_i, by);
      pb2_q <= sd(cy, by) * sd(in_x_i, bx);
      pc1_q <= sd(ax, cx) * sd(in_y_i, cy);
      pc2_q <= sd(ay, cy) * sd(in_x_i, cx);
      x1_q  <= in_x_i;
      y1_q  <= in_y_i;
    end
  end

  // stage two: edge values and coverage
  logic signed [EW-1:0] ea, eb, ec;
  logic [PW-1:0]        ea_q, eb_q, ec_q;
  logic [N-1:0]         x2_q, y2_q;
  logic                 cov_q;
  assign ea = sub2(pa1_q, pa2_q);
  assign eb = sub2(pb1_q, pb2_q);
  assign ec = sub2(pc1_q, pc2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ea_q  <= ea[PW-1:0];
      eb_q  <= eb[PW-1:0];
      ec_q  <= ec[PW-1:0];
      cov_q <= area_pos && !ea[EW-1] && !eb[EW-1] && !ec[EW-1];
      x2_q  <= x1_q;
      y2_q  <= y1_q;
    end
  end

  assign x_o       = x2_q;
  assign y_o       = y2_q;
  assign cov_o     = cov_q;
  assign ea_o      = ea_q;
  assign eb_o      = eb_q;
  assign ec_o      = ec_q;
  assign area_o    = area_q;
  assign color_a_o = ca_q;
  assign color_b_o = cb_q;
  assign color_c_o = cc_q;

endmodule

// ===== hdl/bgs_back.sv =====
// ----------------------------------------------------------------------------
// bgs_back
// Weighted color sums and a pipelined restoring divider by the area.
// ----------------------------------------------------------------------------
module bgs_back #(
  parameter int COORD_BITS = bgs_pkg::COORD_BITS_DEF,
  localparam int PW = 2 * COORD_BITS + 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bgs_pkg::fifo_stat_t            stat_i,
  output logic                           pop_o,
  input  logic [COORD_BITS-1:0]          x_i,
  input  logic [COORD_BITS-1:0]          y_i,
  input  logic                           cov_i,
  input  logic [PW-1:0]                  ea_i,
  input  logic [PW-1:0]                  eb_i,
  input  logic [PW-1:0]                  ec_i,
  input  logic [PW-1:0]                  area_i,
  input  logic [bgs_pkg::COLOR_BITS-1:0] color_a_i,
  input  logic [bgs_pkg::COLOR_BITS-1:0] color_b_i,
  input  logic [bgs_pkg::COLOR_BITS-1:0] color_c_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [COORD_BITS-1:0]          out_x_o,
  output logic [COORD_BITS-1:0]          out_y_o,
  output logic                           out_cov_o,
  output logic [bgs_pkg::COLOR_BITS-1:0] out_chan_o
);
  import bgs_pkg::*;

  localparam int N   = COORD_BITS;
  localparam int MW  = PW + CHAN_BITS;
  localparam int W   = MW + 2;
  localparam int NST = QUO_BITS + 2;

  logic en;
  assign en    = !out_valid_o || out_ready_i;
  assign pop_o = en && !stat_i.empty;

  // valid and coordinate chain through all stages
  logic [NST-1:0] v_q;
  logic [N-1:0]   x_q [NST];
  logic [N-1:0]   y_q [NST];
  logic [NST-1:0] cov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], !stat_i.empty};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0]   <= x_i;
      y_q[0]   <= y_i;
      cov_q[0] <= cov_i;
      for (int s = 1; s < NST; s++) begin
        x_q[s]   <= x_q[s-1];
        y_q[s]   <= y_q[s-1];
        cov_q[s] <= cov_q[s-1];
      end
    end
  end

  // products of channels and opposite edge weights
  logic [MW-1:0] pa_q [NUM_CHAN];
  logic [MW-1:0] pb_q [NUM_CHAN];
  logic [MW-1:0] pc_q [NUM_CHAN];
  logic [W-1:0]  num_q [NUM_CHAN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        pa_q[c]  <= color_a_i[c*CHAN_BITS +: CHAN_BITS] * eb_i;
        pb_q[c]  <= color_b_i[c*CHAN_BITS +: CHAN_BITS] * ec_i;
        pc_q[c]  <= color_c_i[c*CHAN_BITS +: CHAN_BITS] * ea_i;
        num_q[c] <= W'(pa_q[c]) + W'(pb_q[c]) + W'(pc_q[c]);
      end
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  logic [W-1:0]        rem_q [QUO_BITS][NUM_CHAN];
  logic [QUO_BITS-1:0] quo_q [QUO_BITS][NUM_CHAN];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
      logic [W-1:0]        rem_in;
      logic [QUO_BITS-1:0] quo_in;
      logic [W:0]          dsh, trial;
      if (k == 0) begin : g_first
        assign rem_in = num_q[c];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[k-1][c];
        assign quo_in = quo_q[k-1][c];
      end
      assign dsh   = {{(W + 1 - PW){1'b0}}, area_i} << (QUO_BITS - 1 - k);
      assign trial = {1'b0, rem_in} - dsh;
      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_q[k][c] <= trial[W] ? rem_in : trial[W-1:0];
          quo_q[k][c] <= {quo_in[QUO_BITS-2:0], !trial[W]};
        end
      end
    end
  end

  // result stage, channels forced to zero when not covered
  assign out_valid_o = v_q[NST-1];
  assign out_x_o     = x_q[NST-1];
  assign out_y_o     = y_q[NST-1];
  assign out_cov_o   = cov_q[NST-1];
  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_out
    assign out_chan_o[c*CHAN_BITS +: CHAN_BITS] =
      cov_q[NST-1] ? quo_q[QUO_BITS-1][c][CHAN_BITS-1:0] : '0;
  end

endmodule

// ===== hdl/barycentric_gradient_shader_unit.sv =====
// Pipeline: edge product and edge value stages, the queue, weighting stages and
// divider stages lie between an accepted pixel and its result.
// Throughput: one pixel per cycle unless stalled; the divider is fully pipelined.
// Reset: asynchronous, active low; clears all vertex and color registers to zero,
// empties the queue and drops every item in flight.
// ----------------------------------------------------------------------------
// barycentric_gradient_shader_unit
// Per-pixel triangle coverage and barycentric color interpolation.
// ----------------------------------------------------------------------------
module barycentric_gradient_shader_unit #(
  parameter int COORD_BITS = bgs_pkg::COORD_BITS_DEF,
  localparam int VW  = 2 * COORD_BITS,
  localparam int CFW = (VW > bgs_pkg::COLOR_BITS) ? VW : bgs_pkg::COLOR_BITS,
  localparam int IDW = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int ODW = ((2 * COORD_BITS + bgs_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bgs_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFW-1:0]                   cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pixel_x, pixel_y
  input  logic [IDW-1:0]                   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_x, out_y, chan0, chan1, chan2
  output logic [ODW-1:0]                   m_axis_tdata,
  // covered
  output logic                             m_axis_tuser
);
  import bgs_pkg::*;

  localparam int N  = COORD_BITS;
  localparam int PW = 2 * N + 2;
  localparam int QW = 2 * N + 1 + 3 * PW;

  fifo_stat_t            stat;
  logic                  push, pop;
  logic [N-1:0]          f_x, f_y, b_x, b_y, o_x, o_y;
  logic                  f_cov, b_cov, o_cov;
  logic [PW-1:0]         f_ea, f_eb, f_ec, b_ea, b_eb, b_ec, area;
  logic [COLOR_BITS-1:0] ca, cb, cc, o_chan;
  logic [QW-1:0]         q_wdata, q_rdata;

  // front: config, edges, coverage
  bgs_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i (s_axis_tvalid),
    .in_x_i     (s_axis_tdata[N-1:0]),
    .in_y_i     (s_axis_tdata[2*N-1:N]),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .push_o     (push),
    .x_o (f_x), .y_o (f_y), .cov_o (f_cov),
    .ea_o (f_ea), .eb_o (f_eb), .ec_o (f_ec),
    .area_o (area), .color_a_o (ca), .color_b_o (cb), .color_c_o (cc)
  );

  // queue between front and back
  assign q_wdata = {f_x, f_y, f_cov, f_ea, f_eb, f_ec};
  assign {b_x, b_y, b_cov, b_ea, b_eb, b_ec} = q_rdata;

  bgs_fifo #(.WIDTH(QW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i, .rst_ni,
    .push_i (push), .data_i (q_wdata),
    .pop_i  (pop),  .data_o (q_rdata),
    .stat_o (stat)
  );

  // back: weighting and division
  bgs_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i, .rst_ni,
    .stat_i (stat), .pop_o (pop),
    .x_i (b_x), .y_i (b_y), .cov_i (b_cov),
    .ea_i (b_ea), .eb_i (b_eb), .ec_i (b_ec),
    .area_i (area), .color_a_i (ca), .color_b_i (cb), .color_c_i (cc),
    .out_valid_o (m_axis_tvalid), .out_ready_i (m_axis_tready),
    .out_x_o (o_x), .out_y_o (o_y), .out_cov_o (o_cov), .out_chan_o (o_chan)
  );

  assign m_axis_tdata = {{(ODW - 2 * N - COLOR_BITS){1'b0}}, o_chan, o_y, o_x};
  assign m_axis_tuser = o_cov;

`ifndef NO_ASSERTIONS
  // the front only stalls on a full queue
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> stat.full)
    else $error("input stalled while queue has room");

  // never push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !stat.full)
    else $error("push into full queue");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  // uncovered pixels carry black
  a_uncov_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (o_chan == '0))
    else $error("uncovered pixel with nonzero color");
`endif

endmodule

// ===== tb/tb_barycentric_gradient_shader_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_barycentric_gradient_shader_unit
// Drives pixel streams through the shader under a series of triangle and color
// settings, predicts coverage and interpolated channels, and checks each result.
// ----------------------------------------------------------------------------
module tb_barycentric_gradient_shader_unit;
  import bgs_pkg::*;

  localparam int CB  = COORD_BITS_DEF;
  localparam int VW  = 2 * CB;
  localparam int CFW = (VW > COLOR_BITS) ? VW : COLOR_BITS;
  localparam int IDW = ((2 * CB + 7) / 8) * 8;
  localparam int ODW = ((2 * CB + COLOR_BITS + 7) / 8) * 8;
  localparam int WATCHDOG = 20000;
  localparam int DRAIN_CYCLES = 40;
  // index past the register list
  localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          covered;
    logic [7:0]    chan[3];
  } shaded_pixel_t;

  // shade predictor and store of expected pixels
  class shade_scoreboard;
    logic [VW-1:0]         vtx[3];
    logic [COLOR_BITS-1:0] col[3];
    shaded_pixel_t         pending[$];
    int                    errors;
    int                    checked;
    int                    covered_cnt;

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFW-1:0] val);
      case (idx)
        REG_VERTEX_A: vtx[0] = val[VW-1:0];
        REG_VERTEX_B: vtx[1] = val[VW-1:0];
        REG_VERTEX_C: vtx[2] = val[VW-1:0];
        REG_COLOR_A:  col[0] = val[COLOR_BITS-1:0];
        REG_COLOR_B:  col[1] = val[COLOR_BITS-1:0];
        REG_COLOR_C:  col[2] = val[COLOR_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [CB-1:0] px, logic [CB-1:0] py);
      shaded_pixel_t p;
      longint ax, ay, bx, by, cx, cy, area, ea, eb, ec, num;
      ax = longint'(vtx[0][CB-1:0]); ay = longint'(vtx[0][VW-1:CB]);
      bx = longint'(vtx[1][CB-1:0]); by = longint'(vtx[1][VW-1:CB]);
      cx = longint'(vtx[2][CB-1:0]); cy = longint'(vtx[2][VW-1:CB]);
      area = (ax - bx) * (ay - cy) - (ax - cx) * (ay - by);
      ea = (bx - ax) * (longint'(py) - ay) - (by - ay) * (longint'(px) - ax);
      eb = (cx - bx) * (longint'(py) - by) - (cy - by) * (longint'(px) - bx);
      ec = (ax - cx) * (longint'(py) - cy) - (ay - cy) * (longint'(px) - cx);
      p.x = px;
      p.y = py;
      p.covered = (area >= 1 && ea >= 0 && eb >= 0 && ec >= 0);
      for (int k = 0; k < 3; k++) begin
        p.chan[k] = 8'd0;
        if (p.covered) begin
          num = longint'(col[0][8*k +: 8]) * eb + longint'(col[1][8*k +: 8]) * ec
              + longint'(col[2][8*k +: 8]) * ea;
          p.chan[k] = 8'(num / area);
        end
      end
      pending.push_back(p);
    endfunction

    function void check_pixel(logic [ODW-1:0] d, logic cov);
      shaded_pixel_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result x=%0d y=%0d", d[CB-1:0], d[2*CB-1:CB]);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.covered) covered_cnt++;
      if (d[CB-1:0] !== e.x) begin
        $error("out_x exp %0d got %0d", e.x, d[CB-1:0]); errors++;
      end
      if (d[2*CB-1:CB] !== e.y) begin
        $error("out_y exp %0d got %0d", e.y, d[2*CB-1:CB]); errors++;
      end
      if (cov !== e.covered) begin
        $error("covered exp %0d got %0d", e.covered, cov); errors++;
      end
      for (int k = 0; k < 3; k++)
        if (d[2*CB + 8*k +: 8] !== e.chan[k]) begin
          $error("chan%0d exp %0d got %0d", k, e.chan[k], d[2*CB + 8*k +: 8]);
          errors++;
        end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFW-1:0] cfg_data_i;
  logic s_axis_tvalid, s_axis_tready;
  logic [IDW-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [ODW-1:0] m_axis_tdata;
  logic m_axis_tuser;

  shade_scoreboard sb;
  int  idle_cycles;
  bit  long_hold;   // receiver holds off for a long stretch
  bit  stall_mode;

  barycentric_gradient_shader_unit u_dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver stall pattern and result checking
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        sb.check_pixel(m_axis_tdata, m_axis_tuser);
      if (long_hold) begin
        hold = 300;
        long_hold = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (!stall_mode) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog on cycles with no accepted item
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_triangle(logic [VW-1:0] a, logic [VW-1:0] b, logic [VW-1:0] c,
                              logic [23:0] ca, logic [23:0] cb_, logic [23:0] cc);
    write_reg(REG_VERTEX_A, CFW'(a));
    write_reg(REG_VERTEX_B, CFW'(b));
    write_reg(REG_VERTEX_C, CFW'(c));
    write_reg(REG_COLOR_A, CFW'(ca));
    write_reg(REG_COLOR_B, CFW'(cb_));
    write_reg(REG_COLOR_C, CFW'(cc));
  endtask

  // offer one pixel, hold until accepted, with random gaps between bursts
  int burst_left;
  task automatic send_pixel(logic [CB-1:0] px, logic [CB-1:0] py);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IDW'({py, px});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(px, py);
  endtask

  task automatic end_stream();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [VW-1:0] vert(int x, int y);
    return VW'((y << CB) | x);
  endfunction

  // pixel inside the current triangle's bounding box, or at times anywhere
  task automatic send_box_pixel();
    int x0, x1, y0, y1, t;
    x0 = 1023; x1 = 0; y0 = 1023; y1 = 0;
    for (int k = 0; k < 3; k++) begin
      t = int'(sb.vtx[k][CB-1:0]);  x0 = (t < x0) ? t : x0; x1 = (t > x1) ? t : x1;
      t = int'(sb.vtx[k][VW-1:CB]); y0 = (t < y0) ? t : y0; y1 = (t > y1) ? t : y1;
    end
    if ($urandom_range(0, 9) == 0)
      send_pixel(CB'($urandom), CB'($urandom));
    else
      send_pixel(CB'($urandom_range(x0, x1)), CB'($urandom_range(y0, y1)));
  endtask

  initial begin
    sb = new();
    sb.errors = 0; sb.checked = 0; sb.covered_cnt = 0;
    foreach (sb.vtx[k]) begin sb.vtx[k] = '0; sb.col[k] = '0; end
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    long_hold = 1'b0; stall_mode = 1'b0; burst_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: degenerate triangle culls everything
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    end_stream();

    // full-size triangle with extreme colors, in the winding that culls
    set_triangle(vert(0, 0), vert(0, 1023), vert(1023, 1023),
                 24'hFFFFFF, 24'h000000, 24'hFF00FF);
    send_pixel(0, 0);
    send_pixel(0, 1023);
    send_pixel(1023, 1023);
    send_pixel(1023, 0);
    send_pixel(512, 700);
    send_pixel(700, 512);
    send_pixel(511, 511);
    send_pixel(10'h2AA, 10'h355);
    send_pixel(10'h155, 10'h2AA);
    end_stream();

    // reversed winding covers, and an out-of-range index is ignored
    set_triangle(vert(0, 0), vert(1023, 1023), vert(0, 1023),
                 24'h123456, 24'hABCDEF, 24'h00FF00);
    write_reg(REG_NONE, '1);
    send_pixel(0, 1023);
    send_pixel(100, 900);
    end_stream();

    // collinear vertices give zero area
    set_triangle(vert(0, 0), vert(5, 5), vert(10, 10), 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_pixel(5, 5);
    end_stream();

    // smallest triangle, doubled signed area of minus one
    set_triangle(vert(0, 0), vert(0, 1), vert(1, 0), 24'hFFFFFF, 24'h808080, 24'h010101);
    send_pixel(0, 0);
    send_pixel(0, 1);
    send_pixel(1, 0);
    send_pixel(1, 1);
    end_stream();

    // random triangles and pixels
    for (int phase = 0; phase < 26; phase++) begin
      stall_mode = phase[0];
      if (phase % 3 == 0)
        set_triangle(vert($urandom_range(0, 40), $urandom_range(0, 40)),
                     vert($urandom_range(0, 40), $urandom_range(60, 100)),
                     vert($urandom_range(60, 100), $urandom_range(60, 100)),
                     24'($urandom), 24'($urandom), 24'($urandom));
      else
        set_triangle(VW'($urandom), VW'($urandom), VW'($urandom),
                     24'($urandom), 24'($urandom), 24'($urandom));
      if (phase == 5) long_hold = 1'b1;
      repeat (50) send_box_pixel();
      end_stream();
    end

    $display("checked %0d shaded pixels over 31 register settings, %0d of them covered",
             sb.checked, sb.covered_cnt);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
